### rtl/assert_macros.svh
// Assertion helpers shared by the cipher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define PDC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define PDC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/pdc_pkg.sv
package pdc_pkg;

    // s_mode codes
    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_TEXT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic key_accept;
        logic text_accept;
        logic fill_step;
        logic decide;
        logic flush_pair;
        logic flush_error;
        logic look1;
        logic look2;
        logic emit_a;
        logic emit_b;
    } pdc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic complete;
        logic fill_last;
        logic pair_now;
        logic flush_needed;
        logic direction;
        logic out_free;
    } pdc_status_t;

endpackage

### rtl/pdc_ctrl.sv
`include "assert_macros.svh"

module pdc_ctrl
    import pdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_mode,
    output logic        s_ready,
    input  pdc_status_t status,
    output pdc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_DECIDE,
        ST_LOOK1,
        ST_LOOK2,
        ST_EMIT_A,
        ST_EMIT_B,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_mode == MODE_TEXT) begin
                        cmd.text_accept = 1'b1;
                        state_next = status.complete ? ST_DECIDE : ST_FILL;
                    end else begin
                        cmd.key_accept = 1'b1;
                    end
                end
            end
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (status.fill_last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = status.pair_now ? ST_LOOK1 : ST_FLUSH;
            end
            ST_LOOK1: begin
                cmd.look1  = 1'b1;
                state_next = ST_LOOK2;
            end
            ST_LOOK2: begin
                cmd.look2  = 1'b1;
                state_next = ST_EMIT_A;
            end
            ST_EMIT_A: begin
                if (status.out_free) begin
                    cmd.emit_a = 1'b1;
                    state_next = ST_EMIT_B;
                end
            end
            ST_EMIT_B: begin
                if (status.out_free) begin
                    cmd.emit_b = 1'b1;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // odd tail on a last byte: pad with X, or flag on decrypt
                if (status.flush_needed) begin
                    if (status.direction) begin
                        cmd.flush_pair = 1'b1;
                        state_next = ST_LOOK1;
                    end else if (status.out_free) begin
                        cmd.flush_error = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `PDC_ASSERT(a_cmd_onehot, aclk, aresetn, $onehot0(cmd), "more than one datapath command")
    `PDC_ASSERT(a_look_order, aclk, aresetn, cmd.look2 |-> $past(cmd.look1), "square read without place read")
    `PDC_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (state_reg == ST_IDLE), "not idle after reset")

endmodule

### rtl/pdc_datapath.sv
`include "assert_macros.svh"

module pdc_datapath
    import pdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_direction,
    input  logic [7:0]  s_char_byte,
    input  logic        s_first,
    input  logic        s_last,
    input  pdc_cmd_t    cmd,
    output pdc_status_t status,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_letter,
    output logic        m_last_out,
    output logic        m_error
);

    localparam int unsigned LETTERS = 26;
    localparam int unsigned SIDE    = 5;
    localparam int unsigned CELLS   = SIDE * SIDE;
    localparam logic [4:0]  LET_I   = 5'd8;
    localparam logic [4:0]  LET_J   = 5'd9;
    localparam logic [4:0]  LET_X   = 5'd23;

    function automatic logic [2:0] pos_row(input logic [4:0] p);
        pos_row = (p >= 5'd20) ? 3'd4 :
                  (p >= 5'd15) ? 3'd3 :
                  (p >= 5'd10) ? 3'd2 :
                  (p >= 5'd5)  ? 3'd1 : 3'd0;
    endfunction

    function automatic logic [4:0] cell_pos(input logic [2:0] r, input logic [2:0] c);
        cell_pos = {r, 2'b00} + 5'(r) + 5'(c);
    endfunction

    function automatic logic [2:0] pos_col(input logic [4:0] p);
        logic [4:0] base;
        base    = cell_pos(pos_row(p), 3'd0);
        pos_col = 3'(p - base);
    endfunction

    // right/down when encrypting, left/up when decrypting
    function automatic logic [2:0] shift(input logic [2:0] v, input logic fwd);
        if (fwd) begin
            shift = (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
        end else begin
            shift = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
        end
    endfunction

    logic               dir_reg;
    logic [LETTERS-1:0] used_reg, used_next, used_base;
    logic [4:0]         fill_reg, fill_next, fill_base;
    logic               complete_reg, complete_next;
    logic [4:0]         pend_letter_reg, pend_letter_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [4:0]         txt_letter_reg;
    logic               txt_isletter_reg;
    logic               txt_last_reg;
    logic [4:0]         sweep_reg, sweep_next;
    logic [4:0]         op_a_reg, op_a_next, op_b_reg, op_b_next;
    logic [4:0]         place_a_reg, place_b_reg;
    logic [4:0]         sq_a_reg, sq_b_reg;
    logic               out_valid_reg;
    logic [4:0]         out_letter_reg;
    logic               out_last_reg, out_err_reg;

    logic [4:0] place_mem [LETTERS];
    logic [4:0] sq_mem    [CELLS];

    logic       in_is_letter;
    logic [4:0] in_raw, in_letter;
    logic       place_en, do_place;
    logic [4:0] place_l;
    logic       dbl;
    logic [2:0] ra, ca, rb, cb;
    logic [4:0] addr_a, addr_b;

    // 'A' and 'a' both have low bits 00001
    always_comb begin
        in_is_letter = ((s_char_byte >= 8'h41) && (s_char_byte <= 8'h5a)) ||
                       ((s_char_byte >= 8'h61) && (s_char_byte <= 8'h7a));
        in_raw       = s_char_byte[4:0] - 5'd1;
        in_letter    = (in_raw == LET_J) ? LET_I : in_raw;
    end

    // square build: keyword letters, then the completion sweep
    always_comb begin
        used_base     = used_reg;
        fill_base     = fill_reg;
        complete_next = complete_reg;
        place_en      = 1'b0;
        place_l       = in_letter;
        if (cmd.key_accept) begin
            if (s_first) begin
                used_base     = '0;
                fill_base     = '0;
                complete_next = 1'b0;
            end
            place_en = in_is_letter && (s_first || !complete_reg);
        end else if (cmd.fill_step) begin
            place_l  = sweep_reg;
            place_en = (sweep_reg != LET_J);
            if (status.fill_last) begin
                complete_next = 1'b1;
            end
        end
        do_place  = place_en && !used_base[place_l] && (fill_base < 5'(CELLS));
        used_next = used_base;
        fill_next = fill_base;
        if (do_place) begin
            used_next[place_l] = 1'b1;
            fill_next          = fill_base + 5'd1;
        end
    end

    assign sweep_next = cmd.text_accept ? 5'd0 : (cmd.fill_step ? sweep_reg + 5'd1 : sweep_reg);

    // pairing of text letters
    assign dbl = dir_reg && (pend_letter_reg == txt_letter_reg);

    always_comb begin
        pend_letter_next = pend_letter_reg;
        pend_valid_next  = pend_valid_reg;
        op_a_next        = op_a_reg;
        op_b_next        = op_b_reg;
        if (cmd.text_accept && s_first) begin
            pend_valid_next = 1'b0;
        end
        if (cmd.decide && txt_isletter_reg) begin
            if (!pend_valid_reg) begin
                pend_letter_next = txt_letter_reg;
                pend_valid_next  = 1'b1;
            end else begin
                op_a_next = pend_letter_reg;
                op_b_next = dbl ? LET_X : txt_letter_reg;
                // a doubled letter stays pending behind the inserted X
                if (!dbl) begin
                    pend_valid_next = 1'b0;
                end
            end
        end
        if (cmd.flush_pair) begin
            op_a_next       = pend_letter_reg;
            op_b_next       = LET_X;
            pend_valid_next = 1'b0;
        end
        if (cmd.flush_error) begin
            pend_valid_next = 1'b0;
        end
    end

    // row, column and rectangle rules
    always_comb begin
        ra = pos_row(place_a_reg);
        ca = pos_col(place_a_reg);
        rb = pos_row(place_b_reg);
        cb = pos_col(place_b_reg);
        if (ra == rb) begin
            addr_a = cell_pos(ra, shift(ca, dir_reg));
            addr_b = cell_pos(rb, shift(cb, dir_reg));
        end else if (ca == cb) begin
            addr_a = cell_pos(shift(ra, dir_reg), ca);
            addr_b = cell_pos(shift(rb, dir_reg), cb);
        end else begin
            addr_a = cell_pos(ra, cb);
            addr_b = cell_pos(rb, ca);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg        <= 1'b1;
            used_reg       <= '0;
            fill_reg       <= '0;
            complete_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                dir_reg <= cfg_direction;
            end
            used_reg       <= used_next;
            fill_reg       <= fill_next;
            complete_reg   <= complete_next;
            pend_valid_reg <= pend_valid_next;
            if (cmd.emit_a || cmd.emit_b || cmd.flush_error) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_letter_reg <= pend_letter_next;
        sweep_reg       <= sweep_next;
        op_a_reg        <= op_a_next;
        op_b_reg        <= op_b_next;
        if (cmd.text_accept) begin
            txt_letter_reg   <= in_letter;
            txt_isletter_reg <= in_is_letter;
            txt_last_reg     <= s_last;
        end
        if (cmd.emit_a) begin
            out_letter_reg <= sq_a_reg;
            out_last_reg   <= 1'b0;
            out_err_reg    <= 1'b0;
        end else if (cmd.emit_b) begin
            out_letter_reg <= sq_b_reg;
            out_last_reg   <= txt_last_reg && !pend_valid_reg;
            out_err_reg    <= 1'b0;
        end else if (cmd.flush_error) begin
            out_letter_reg <= 5'd0;
            out_last_reg   <= 1'b1;
            out_err_reg    <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_place) begin
            sq_mem[fill_base]  <= place_l;
            place_mem[place_l] <= fill_base;
        end
        if (cmd.look1) begin
            place_a_reg <= place_mem[op_a_reg];
            place_b_reg <= place_mem[op_b_reg];
        end
        if (cmd.look2) begin
            sq_a_reg <= sq_mem[addr_a];
            sq_b_reg <= sq_mem[addr_b];
        end
    end

    always_comb begin
        status.complete     = complete_reg;
        status.fill_last    = (sweep_reg == 5'(LETTERS - 1));
        status.pair_now     = txt_isletter_reg && pend_valid_reg;
        status.flush_needed = txt_last_reg && pend_valid_reg;
        status.direction    = dir_reg;
        status.out_free     = !out_valid_reg || m_ready;
    end

    assign m_valid    = out_valid_reg;
    assign m_letter   = out_letter_reg;
    assign m_last_out = out_last_reg;
    assign m_error    = out_err_reg;

    `PDC_ASSERT(a_load_free, aclk, aresetn, (cmd.emit_a || cmd.emit_b || cmd.flush_error) |-> (!out_valid_reg || m_ready), "result register overwritten")
    `PDC_ASSERT(a_square_ready, aclk, aresetn, cmd.decide |-> complete_reg, "pairing before square complete")
    `PDC_ASSERT(a_fill_bound, aclk, aresetn, do_place |=> (fill_reg <= 5'(CELLS)), "square overfilled")

endmodule

### rtl/playfair_digraph_cipher_top.sv
// A keyword byte is taken in the idle state. A text byte goes to decide, then, if it closes
// a pair, to the place lookup, the square lookup and the emission of both letters, then the tail flush.
// The first text byte after a keyword first runs the completion sweep of the square.
// Pair lookups read the letter-position memory, then the square memory.
// Reset (aresetn, synchronous, active low): empty square, no pending letter, direction 1.
module playfair_digraph_cipher_top
    import pdc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_direction,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_mode,
    input  logic [7:0] s_char_byte,
    input  logic       s_first,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_letter,
    output logic       m_last_out,
    output logic       m_error
);

    pdc_cmd_t    cmd;
    pdc_status_t status;

    assign cfg_ready = 1'b1;

    pdc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pdc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_direction (cfg_direction),
        .s_char_byte   (s_char_byte),
        .s_first       (s_first),
        .s_last        (s_last),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_letter      (m_letter),
        .m_last_out    (m_last_out),
        .m_error       (m_error)
    );

endmodule
